/* hdl/periodic_slot_scheduler_unit_macros.svh */
// assertion macros for the periodic slot scheduler checks
`ifndef PERIODIC_SLOT_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_SLOT_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic slot scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define PSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic slot scheduler check failed");

`endif

/* hdl/pss_pkg.sv */
// shared constants and types of the periodic slot scheduler
package pss_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int TICK_W    = 64;
    localparam int DUR_W     = 32;
    localparam int SLOT_W    = 2;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_EXECUTE  = 2'd0;
    localparam logic [1:0] KIND_SLIPPAGE = 2'd1;
    localparam logic [1:0] KIND_HALTED   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUR_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT    = 3'd5;

    // remainder unit handshake
    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [DUR_W-1:0]  divisor;
    } rem_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DUR_W-1:0] rem;
    } rem_stat_t;

endpackage

/* hdl/pss_rem_unit.sv */
// bit-serial restoring remainder of a 64-bit dividend by a 32-bit divisor
module pss_rem_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  pss_pkg::rem_req_t  req,
    output pss_pkg::rem_stat_t stat
);
    import pss_pkg::*;

    localparam int STEP_W = $clog2(TICK_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TICK_W-1:0] dvd_reg;
    logic [DUR_W-1:0]  dvs_reg;
    logic [DUR_W-1:0]  rem_reg;

    logic [DUR_W:0]    trial;
    logic              fits;
    logic [DUR_W-1:0]  rem_next;

    // one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TICK_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DUR_W'(trial - {1'b0, dvs_reg}) : trial[DUR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                dvd_reg  <= {dvd_reg[TICK_W-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TICK_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

/* hdl/periodic_slot_scheduler_unit.sv */
// top level of the periodic slot scheduler
// Periodic slot scheduler. Keeps a 64-bit time marker for each of up to four
// slots and takes tick, start and stop requests on a valid/ready input. Start
// arms the scheduler so that the next tick loads every scanned marker with
// that tick; stop disarms it. A tick while running scans slots from zero up to
// slots_in_use (capped at four); an expired slot advances its marker by its
// duration and emits an execute result, a set fail bit emits a halted result
// and stops the scheduler, and a slot still expired after the advance emits a
// slippage result (if report_slippage is set) and has its marker set to the
// tick rounded down to a multiple of its duration. Results leave one at a
// time on a valid/ready output; last_of_tick marks the final result of a tick.
// Start, stop and ticks while stopped are handled in the idle state. A tick
// takes each scanned slot through a check and, if it expired, an advance, an
// execute result and a second check, then where due a slippage result and
// the resync, which divides for a nonzero duration; then it closes the scan.
// The rounding runs on a bit-serial remainder unit, one bit of the 64-bit
// tick per cycle. A stalled output holds the scan wherever a result is due
// and an earlier result is still held back. The block takes no new request
// while a tick is in work. Registers must be written by the user through
// cfg_write/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. Indexes past five are ignored.
module periodic_slot_scheduler_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pss_pkg::CFG_DAT_W-1:0]   cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic [pss_pkg::TICK_W-1:0]      now_tick,
    input  logic [pss_pkg::NUM_SLOTS-1:0]   fail_mask,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      event_kind,
    output logic [pss_pkg::SLOT_W-1:0]      slot_index,
    output logic [pss_pkg::TICK_W-1:0]      event_tick,
    output logic [pss_pkg::TICK_W-1:0]      slot_marker,
    output logic                            last_of_tick
);
    import pss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADV,
        S_EXEC,
        S_HALT,
        S_CHECK2,
        S_SLIP,
        S_ROUND,
        S_DIV,
        S_NEXT,
        S_FINISH,
        S_FLUSH
    } state_t;

    // configuration registers
    logic [DUR_W-1:0] duration_reg [NUM_SLOTS];
    logic [CNT_W-1:0] slots_in_use_reg;
    logic             report_slippage_reg;

    // scheduler state
    state_t            state_reg;
    logic              running_reg;
    logic              first_pass_reg;
    logic [TICK_W-1:0] markers_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] slot_reg;
    logic [TICK_W-1:0] now_reg;
    logic [NUM_SLOTS-1:0] fail_reg;
    logic [TICK_W-1:0] mk_reg;

    // one result held back until we know whether it ends the tick
    logic              pend_valid_reg;
    logic [1:0]        pend_kind_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [TICK_W-1:0] pend_marker_reg;

    // output register
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [TICK_W-1:0] out_tick_reg;
    logic [TICK_W-1:0] out_marker_reg;
    logic              out_last_reg;

    // remainder unit link
    rem_req_t  rem_req;
    rem_stat_t rem_stat;

    logic [CNT_W-1:0]  scan_count;
    logic [DUR_W-1:0]  dur_cur;
    logic [TICK_W-1:0] dur_ext;
    logic [TICK_W-1:0] marker_cur;
    logic [TICK_W-1:0] cmp_marker;
    logic [TICK_W-1:0] elapsed;
    logic              expired;
    logic              slot_last;
    logic              can_push;
    logic              emit_req;
    logic              emit_go;
    logic [1:0]        emit_kind;
    logic              flush_go;

    pss_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    always_comb
    begin
        // slots_in_use saturates at the slot count
        scan_count = (slots_in_use_reg > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                           : slots_in_use_reg;
        dur_cur    = duration_reg[slot_reg];
        dur_ext    = {{(TICK_W-DUR_W){1'b0}}, dur_cur};
        // first pass loads the marker with the tick itself
        marker_cur = first_pass_reg ? now_reg : markers_reg[slot_reg];
        // one elapsed-time compare shared by both expiry checks
        cmp_marker = (state_reg == S_CHECK) ? marker_cur : mk_reg;
        elapsed    = now_reg - cmp_marker;
        expired    = elapsed >= dur_ext;
        slot_last  = (CNT_W'(slot_reg) + CNT_W'(1)) == scan_count;

        // output register free this cycle
        can_push   = !out_valid_reg || out_ready;

        emit_req   = (state_reg == S_EXEC) || (state_reg == S_HALT) ||
                     (state_reg == S_SLIP);
        emit_go    = emit_req && (!pend_valid_reg || can_push);
        flush_go   = (state_reg == S_FLUSH) && can_push;

        unique case (state_reg)
            S_HALT:  emit_kind = KIND_HALTED;
            S_SLIP:  emit_kind = KIND_SLIPPAGE;
            default: emit_kind = KIND_EXECUTE;
        endcase

        rem_req.start    = (state_reg == S_ROUND) && (dur_cur != '0);
        rem_req.dividend = now_reg;
        rem_req.divisor  = dur_cur;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                duration_reg[i] <= '0;
            end
            slots_in_use_reg    <= '0;
            report_slippage_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DUR_ZERO:  duration_reg[0] <= cfg_data[DUR_W-1:0];
                REG_DUR_ONE:   duration_reg[1] <= cfg_data[DUR_W-1:0];
                REG_DUR_TWO:   duration_reg[2] <= cfg_data[DUR_W-1:0];
                REG_DUR_THREE: duration_reg[3] <= cfg_data[DUR_W-1:0];
                REG_SLOTS:     slots_in_use_reg <= cfg_data[CNT_W-1:0];
                REG_REPORT:    report_slippage_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // sequencer, markers and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= 1'b0;
            first_pass_reg <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                markers_reg[i] <= '0;
            end
        end
        else
        begin
            if (emit_go && pend_valid_reg)
            begin
                // new result: older held result goes out, not last of tick
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= pend_kind_reg;
                out_slot_reg   <= pend_slot_reg;
                out_tick_reg   <= now_reg;
                out_marker_reg <= pend_marker_reg;
                out_last_reg   <= 1'b0;
            end
            else if (flush_go)
            begin
                // tick over: held result goes out as last
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= pend_kind_reg;
                out_slot_reg   <= pend_slot_reg;
                out_tick_reg   <= now_reg;
                out_marker_reg <= pend_marker_reg;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                // result taken downstream
                out_valid_reg <= 1'b0;
            end

            if (emit_go)
            begin
                pend_valid_reg  <= 1'b1;
                pend_kind_reg   <= emit_kind;
                pend_slot_reg   <= slot_reg;
                pend_marker_reg <= mk_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg  <= now_tick;
                        fail_reg <= fail_mask;
                        slot_reg <= '0;
                        unique case (opcode)
                            OP_START:
                            begin
                                running_reg    <= 1'b1;
                                first_pass_reg <= 1'b1;
                            end
                            OP_STOP:
                            begin
                                running_reg <= 1'b0;
                            end
                            OP_TICK:
                            begin
                                if (running_reg)
                                begin
                                    state_reg <= (scan_count == '0) ? S_FINISH : S_CHECK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK:
                begin
                    markers_reg[slot_reg] <= marker_cur;
                    mk_reg                <= marker_cur;
                    state_reg             <= expired ? S_ADV : S_NEXT;
                end
                S_ADV:
                begin
                    mk_reg                <= mk_reg + dur_ext;
                    markers_reg[slot_reg] <= mk_reg + dur_ext;
                    state_reg             <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (emit_go)
                    begin
                        state_reg <= fail_reg[slot_reg] ? S_HALT : S_CHECK2;
                    end
                end
                S_HALT:
                begin
                    // first_pass keeps its value on a halt
                    if (emit_go)
                    begin
                        running_reg <= 1'b0;
                        state_reg   <= S_FLUSH;
                    end
                end
                S_CHECK2:
                begin
                    if (expired)
                    begin
                        state_reg <= report_slippage_reg ? S_SLIP : S_ROUND;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_SLIP:
                begin
                    if (emit_go)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    // zero duration resyncs straight to the tick
                    if (dur_cur == '0)
                    begin
                        markers_reg[slot_reg] <= now_reg;
                        state_reg             <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // round down: tick minus its remainder by the duration
                    if (rem_stat.done)
                    begin
                        markers_reg[slot_reg] <= now_reg - {{(TICK_W-DUR_W){1'b0}}, rem_stat.rem};
                        state_reg             <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (slot_last)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + SLOT_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_FINISH:
                begin
                    first_pass_reg <= 1'b0;
                    state_reg      <= pend_valid_reg ? S_FLUSH : S_IDLE;
                end
                S_FLUSH:
                begin
                    if (flush_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign slot_index   = out_slot_reg;
    assign event_tick   = out_tick_reg;
    assign slot_marker  = out_marker_reg;
    assign last_of_tick = out_last_reg;

endmodule

/* hdl/pss_checker.sv */
// port-level checks of the periodic slot scheduler, bound to the top level
`include "periodic_slot_scheduler_unit_macros.svh"

module pss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [1:0]                      event_kind,
    input logic [pss_pkg::SLOT_W-1:0]      slot_index,
    input logic [pss_pkg::TICK_W-1:0]      event_tick,
    input logic [pss_pkg::TICK_W-1:0]      slot_marker,
    input logic                            last_of_tick
);
    import pss_pkg::*;

    logic [2+SLOT_W+2*TICK_W:0] out_payload;

    assign out_payload = {event_kind, slot_index, event_tick, slot_marker, last_of_tick};

    // a stalled result holds
    `PSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    `PSS_ASSERT_NXT(a_out_data, out_valid && !out_ready, $stable(out_payload))

    // a halt always closes its tick
    `PSS_ASSERT_IMP(a_halt_last, out_valid && (event_kind == KIND_HALTED), last_of_tick)

    // while idle only the closing result of a tick can still wait
    `PSS_ASSERT_IMP(a_idle_last, in_ready && out_valid, last_of_tick)

endmodule

bind periodic_slot_scheduler_unit pss_checker u_pss_checker (.*);

/* sim/slot_event_checker.sv */
// predictor and result checker for the periodic slot scheduler testbench
module slot_event_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pss_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [pss_pkg::TICK_W-1:0]     now_tick,
    input  logic [pss_pkg::NUM_SLOTS-1:0]  fail_mask,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [1:0]                     event_kind,
    input  logic [pss_pkg::SLOT_W-1:0]     slot_index,
    input  logic [pss_pkg::TICK_W-1:0]     event_tick,
    input  logic [pss_pkg::TICK_W-1:0]     slot_marker,
    input  logic                           last_of_tick,
    output int unsigned                    failures,
    output int unsigned                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import pss_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] marker;
        logic              last;
    } sched_event_t;

    sched_event_t      expected_events [$];

    // shadow copy of the scheduler state and its registers
    logic [DUR_W-1:0]  period [NUM_SLOTS];
    logic [CNT_W-1:0]  scan_limit;
    logic              report_slip;
    logic [TICK_W-1:0] markers [NUM_SLOTS];
    logic              armed;
    logic              first_scan;
    int unsigned       fail_total;

    function automatic void push_event(input logic [1:0] kind, input int slot,
                                       input logic [TICK_W-1:0] tick,
                                       input logic [TICK_W-1:0] marker);
        sched_event_t ev;
        ev.kind   = kind;
        ev.slot   = slot[SLOT_W-1:0];
        ev.tick   = tick;
        ev.marker = marker;
        ev.last   = 1'b0;
        expected_events.push_back(ev);
    endfunction

    // apply one request to the shadow state and queue the results it causes
    function automatic void predict_request(input logic [1:0] op,
                                            input logic [TICK_W-1:0] now,
                                            input logic [NUM_SLOTS-1:0] fails);
        int                slot_count;
        int                s;
        int                first_new;
        bit                halted;
        logic [TICK_W-1:0] dur;
        first_new = expected_events.size();
        halted    = 1'b0;
        if (op == OP_START) begin
            armed      = 1'b1;
            first_scan = 1'b1;
        end else if (op == OP_STOP) begin
            armed = 1'b0;
        end else if (op == OP_TICK && armed) begin
            slot_count = (scan_limit > NUM_SLOTS) ? NUM_SLOTS : int'(scan_limit);
            for (s = 0; s < slot_count && !halted; s++) begin
                dur = {{(TICK_W-DUR_W){1'b0}}, period[s]};
                if (first_scan)
                    markers[s] = now;
                if (now - markers[s] >= dur) begin
                    markers[s] = markers[s] + dur;
                    push_event(KIND_EXECUTE, s, now, markers[s]);
                    if (fails[s]) begin
                        push_event(KIND_HALTED, s, now, markers[s]);
                        armed  = 1'b0;
                        halted = 1'b1;
                    end else if (now - markers[s] >= dur) begin
                        if (report_slip)
                            push_event(KIND_SLIPPAGE, s, now, markers[s]);
                        if (dur == '0)
                            markers[s] = now;
                        else
                            markers[s] = now - (now % dur);
                    end
                end
            end
            if (!halted)
                first_scan = 1'b0;
            if (expected_events.size() > first_new)
                expected_events[expected_events.size()-1].last = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sched_event_t ev;
        if (!rst_n) begin
            expected_events.delete();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                period[i]  = '0;
                markers[i] = '0;
            end
            scan_limit  = '0;
            report_slip = 1'b0;
            armed       = 1'b0;
            first_scan  = 1'b1;
            fail_total  = 0;
            failures    <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_DUR_ZERO:  period[0]   = cfg_data;
                    REG_DUR_ONE:   period[1]   = cfg_data;
                    REG_DUR_TWO:   period[2]   = cfg_data;
                    REG_DUR_THREE: period[3]   = cfg_data;
                    REG_SLOTS:     scan_limit  = cfg_data[CNT_W-1:0];
                    REG_REPORT:    report_slip = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_request(opcode, now_tick, fail_mask);
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0) begin
                    if (fail_total < 10)
                        $display("unexpected result: kind %0d slot %0d tick %h marker %h last %0d",
                                 event_kind, slot_index, event_tick, slot_marker, last_of_tick);
                    fail_total++;
                end else begin
                    ev = expected_events.pop_front();
                    if (ev.kind !== event_kind || ev.slot !== slot_index ||
                        ev.tick !== event_tick || ev.marker !== slot_marker ||
                        ev.last !== last_of_tick) begin
                        if (fail_total < 10) begin
                            $display("result mismatch: expected kind %0d slot %0d tick %h marker %h last %0d",
                                     ev.kind, ev.slot, ev.tick, ev.marker, ev.last);
                            $display("                 actual   kind %0d slot %0d tick %h marker %h last %0d",
                                     event_kind, slot_index, event_tick, slot_marker, last_of_tick);
                        end
                        fail_total++;
                    end
                end
            end
            failures    <= fail_total;
            outstanding <= expected_events.size();
        end
    end

endmodule

/* sim/testbench.sv */
// stimulus and verdict for the periodic slot scheduler
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pss_pkg::*;

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register indexes past the map, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;
    // wide margin for a tick still in work that owes no result
    localparam int SETTLE_CYCLES = 320;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode = OP_TICK;
    logic [TICK_W-1:0]    now_tick = '0;
    logic [NUM_SLOTS-1:0] fail_mask = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           event_kind;
    logic [SLOT_W-1:0]    slot_index;
    logic [TICK_W-1:0]    event_tick;
    logic [TICK_W-1:0]    slot_marker;
    logic                 last_of_tick;
    int unsigned          failures;
    int unsigned          outstanding;

    // idling percentages of the current phase
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    // hold-off handshake between the stimulus and the ready process
    logic                 hold_toggle = 1'b0;
    logic                 hold_seen = 1'b0;
    int                   hold_left = 0;
    // running tick value of the random requests and its step size
    logic [TICK_W-1:0]    cur_tick = '0;
    int                   step_max = 30;

    periodic_slot_scheduler_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .now_tick     (now_tick),
        .fail_mask    (fail_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .slot_index   (slot_index),
        .event_tick   (event_tick),
        .slot_marker  (slot_marker),
        .last_of_tick (last_of_tick)
    );

    slot_event_checker event_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .now_tick     (now_tick),
        .fail_mask    (fail_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .slot_index   (slot_index),
        .event_tick   (event_tick),
        .slot_marker  (slot_marker),
        .last_of_tick (last_of_tick),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver side: random stalls, plus a long hold-off whenever the toggle flips
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // offer one request, return at the edge where it is accepted
    task automatic send_request(input logic [1:0] op, input logic [TICK_W-1:0] tick,
                                input logic [NUM_SLOTS-1:0] mask);
        // random sender gaps, decided anew at each clock
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        now_tick  <= tick;
        fail_mask <= mask;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // drain, then give a result-free tick time to finish before touching registers
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write every register back to back, plus one write to an unmapped index
    task automatic apply_setup(input logic [DUR_W-1:0] d0, input logic [DUR_W-1:0] d1,
                               input logic [DUR_W-1:0] d2, input logic [DUR_W-1:0] d3,
                               input logic [CFG_DAT_W-1:0] slots,
                               input logic [CFG_DAT_W-1:0] report);
        logic [CFG_IDX_W-1:0] idx [7];
        logic [CFG_DAT_W-1:0] val [7];
        idx[0] = REG_DUR_ZERO;  val[0] = d0;
        idx[1] = REG_DUR_ONE;   val[1] = d1;
        idx[2] = REG_DUR_TWO;   val[2] = d2;
        idx[3] = REG_DUR_THREE; val[3] = d3;
        idx[4] = REG_SLOTS;     val[4] = slots;
        idx[5] = REG_REPORT;    val[5] = report;
        idx[6] = $urandom_range(0, 1) ? REG_SPARE_SIX : REG_SPARE_SEVEN;
        val[6] = $urandom;
        for (int i = 0; i < 7; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // random traffic: mostly start followed by runs of ticks, with stops,
    // failures, jumps and ignored opcodes mixed in
    task automatic run_random_phase(input int n_items, input int hold_at, input int pause_at);
        int                   sent;
        int                   pick;
        logic [NUM_SLOTS-1:0] mask;
        sent = 0;
        send_request(OP_START, {$urandom, $urandom}, '0);
        while (sent < n_items) begin
            if (sent == hold_at)
                hold_toggle <= ~hold_toggle;
            if (sent == pause_at)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // ignored request, not counted
                send_request(OP_UNUSED, {$urandom, $urandom}, NUM_SLOTS'($urandom));
            end else begin
                if (pick < 8) begin
                    send_request(OP_STOP, {$urandom, $urandom}, NUM_SLOTS'($urandom));
                end else if (pick < 20) begin
                    if ($urandom_range(0, 1))
                        cur_tick = {$urandom, $urandom};
                    send_request(OP_START, {$urandom, $urandom}, NUM_SLOTS'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        cur_tick = cur_tick + $urandom_range(0, step_max);
                    else if (pick < 85)
                        cur_tick = cur_tick + $urandom;
                    else if (pick < 92)
                        cur_tick = cur_tick - $urandom_range(1, step_max);
                    else
                        cur_tick = {$urandom, $urandom};
                    mask = ($urandom_range(0, 99) < 10) ? NUM_SLOTS'($urandom_range(1, 15)) : '0;
                    send_request(OP_TICK, cur_tick, mask);
                end
                sent++;
            end
        end
    endtask

    initial begin
        // reset once, at the start
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: mixed periods with a zero and a maximal one, slippage reported
        apply_setup(32'd5, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd4, 32'd1);
        send_request(OP_TICK, 64'd50, 4'hF);        // tick while stopped
        send_request(OP_STOP, 64'd0, 4'h0);
        send_request(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        send_request(OP_START, 64'd0, 4'h0);
        send_request(OP_TICK, 64'd100, 4'h0);       // first scan loads markers
        send_request(OP_TICK, 64'd105, 4'h0);       // executes, with slippage on the zero-duration slot
        send_request(OP_TICK, 64'd140, 4'h0);       // slippage and rounding
        send_request(OP_TICK, 64'd141, 4'b0010);    // failure halts the scan
        send_request(OP_TICK, 64'd150, 4'h0);       // halted, nothing
        send_request(OP_START, 64'd0, 4'h0);
        send_request(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFE, 4'h0);
        send_request(OP_TICK, 64'd4, 4'h0);         // wraps past zero
        send_request(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 4'b1000);  // full result burst
        send_request(OP_START, 64'd0, 4'h0);
        send_request(OP_TICK, 64'd0, 4'h0);
        send_request(OP_START, 64'd0, 4'h0);        // re-arm while running
        send_request(OP_TICK, 64'd30, 4'h0);

        // directed: two slots, reporting off, fail bits on unscanned slots
        settle();
        apply_setup(32'd1, 32'h8000_0000, 32'd7, 32'd9, 32'd2, 32'd0);
        send_request(OP_START, 64'd0, 4'h0);
        send_request(OP_TICK, 64'd10, 4'b1100);
        send_request(OP_TICK, 64'd20, 4'b1100);     // slip silently resynced
        send_request(OP_TICK, 64'h0000_0001_0000_0000, 4'h0);

        // directed: no slots scanned
        settle();
        apply_setup(32'd2, 32'd2, 32'd2, 32'd2, 32'd0, 32'd1);
        send_request(OP_START, 64'd0, 4'h0);
        send_request(OP_TICK, 64'd5, 4'hF);
        send_request(OP_TICK, 64'd9, 4'h0);

        // phase one: no idling, small periods, all four slots
        settle();
        step_max = 30;
        apply_setup($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                    $urandom_range(1, 12), 32'd4, 32'd1);
        run_random_phase(38, -1, -1);

        // phase two: sender idles, reporting off, one pause for a full drain
        settle();
        idle_pct  = 59;
        stall_pct = 0;
        apply_setup($urandom_range(1, 12), 32'd0, 32'hFFFF_FFFF, $urandom_range(1, 12),
                    CFG_DAT_W'({$urandom_range(0, 32'h1FFF_FFFF), 3'd3}),
                    CFG_DAT_W'({$urandom_range(0, 32'h7FFF_FFFF), 1'b0}));
        run_random_phase(35, -1, 20);

        // phase three: receiver stalls, slot count saturates, long hold-off
        settle();
        idle_pct  = 0;
        stall_pct = 59;
        apply_setup($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                    $urandom, CFG_DAT_W'({$urandom_range(0, 32'h1FFF_FFFF), 3'd7}),
                    CFG_DAT_W'({$urandom_range(0, 32'h7FFF_FFFF), 1'b1}));
        run_random_phase(38, 15, -1);

        // phase four: both sides idle a little, random slot count and reporting
        settle();
        idle_pct  = 15;
        stall_pct = 15;
        apply_setup(32'd0, $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                    $urandom_range(1, 4), $urandom_range(0, 1));
        run_random_phase(35, -1, -1);

        // drain and let the last tick finish
        settle();

        if (failures == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
